FILE: hw/rtl/idq_pkg.sv
// Shared definitions for the indexed deque: operation codes, swap sequencer
// states, default sizes and stream field widths. No dependencies.
package idq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the stream payloads.
  localparam int OP_W     = 3;
  localparam int IDX_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int OCC_W    = 7;
  localparam int IN_TDATA_W  = 48;   // value, first_index, second_index, padded
  localparam int IN_TUSER_W  = 4;    // operation, remove_front
  localparam int OUT_TDATA_W = 40;   // data_out, occupancy, padded
  localparam int OUT_TUSER_W = 1;    // error

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_GET_FRONT  = 3'd2,
    OP_READ_IDX   = 3'd3,
    OP_WRITE_IDX  = 3'd4,
    OP_SWAP       = 3'd5
  } op_t;

  // Swap write-back: first slot, then second slot.
  typedef enum logic [1:0] {
    SW_IDLE   = 2'd0,
    SW_FIRST  = 2'd1,
    SW_SECOND = 2'd2
  } swap_state_t;

endpackage

FILE: hw/rtl/indexed_deque.sv
// Indexed deque top level: ring buffer of data words with front pointer and
// count, six operations over a stream interface. Depends on idq_pkg.
//
//  channel | direction | tdata (low bit up)                         | tuser (low bit up)
//  --------+-----------+--------------------------------------------+--------------------------
//  in_     | slave     | value[31:0] first_index[37:32]             | operation[2:0]
//          |           | second_index[43:38], zero pad to 48 bits   | remove_front[3]
//  out_    | master    | data_out[31:0] occupancy[38:32], zero pad  | error[0]
//
// A request is decoded, checked and applied in the cycle it is accepted; its result
// sits in the output register from the next cycle on, so requests follow back to back.
// A legal swap of two different positions is the exception: the one slot write port
// writes the first slot in SW_FIRST and the second in SW_SECOND, with the input held off.
// Reset (synchronous, active low) clears pointers, count, swap state and output valid and
// holds in_tready low. A stalled result holds; a new request enters as the old one leaves.
module indexed_deque #(
  parameter int CAPACITY   = idq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: value, first_index, second_index, zero pad.
  input  logic [idq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: operation, remove_front.
  input  logic [idq_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: data_out, occupancy, zero pad.
  output logic [idq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: error.
  output logic [idq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width used to compare request indexes against the count.
  localparam int CMP_W = (CNT_W > idq_pkg::IDX_W) ? CNT_W : idq_pkg::IDX_W;
  localparam logic [PTR_W:0] CAP_EXT  = (PTR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam int PAD_W = idq_pkg::OUT_TDATA_W - idq_pkg::VALUE_W - idq_pkg::OCC_W;

  // Unpacked request fields.
  logic [idq_pkg::OP_W-1:0]    op;
  logic                        remove_front;
  logic [DATA_WIDTH-1:0]       value;
  logic [idq_pkg::IDX_W-1:0]   first_index;
  logic [idq_pkg::IDX_W-1:0]   second_index;

  assign op           = in_tuser[2:0];
  assign remove_front = in_tuser[3];
  assign value        = DATA_WIDTH'(in_tdata[31:0]);
  assign first_index  = in_tdata[37:32];
  assign second_index = in_tdata[43:38];

  // Architectural state.
  logic [DATA_WIDTH-1:0] slots [CAPACITY];
  logic [PTR_W-1:0]      front_r, front_nxt;
  logic [CNT_W-1:0]      held_r, held_nxt;

  // Result register.
  logic                  out_valid_r;
  logic                  res_err_r, res_err_nxt;
  logic                  res_sel_r, res_sel_nxt;
  logic [CNT_W-1:0]      res_occ_r;
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;

  // Swap sequencer.
  idq_pkg::swap_state_t  sw_state_r, sw_state_nxt;
  logic [PTR_W-1:0]      sw_a_r, sw_b_r;
  logic                  swap_busy;
  logic                  swap_start;

  // No request is taken while reset is held, so none can be lost to it.
  logic in_acc;
  assign in_tready = rst_n && (!out_valid_r || out_tready) && !swap_busy;
  assign in_acc    = in_tvalid && in_tready;

  // Physical slot of a position from the front. The sum stays below twice
  // the capacity for any legal position, so one conditional subtract wraps it.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W:0]   offs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + offs;
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0] addr_first, addr_second, addr_back, addr_pfront;
  logic             first_ok, second_ok, full, empty;

  assign addr_first  = phys(front_r, (PTR_W + 1)'(first_index));
  assign addr_second = phys(front_r, (PTR_W + 1)'(second_index));
  assign addr_back   = phys(front_r, (PTR_W + 1)'(held_r));
  assign addr_pfront = (front_r == '0) ? PTR_W'(CAPACITY - 1) : front_r - 1'b1;
  assign first_ok    = CMP_W'(first_index) < CMP_W'(held_r);
  assign second_ok   = CMP_W'(second_index) < CMP_W'(held_r);
  assign full        = (held_r == CAP_CNT);
  assign empty       = (held_r == '0);

  // Decode: error, pointer updates, request-side write and read address.
  logic                  req_we;
  logic [PTR_W-1:0]      req_waddr;
  logic [PTR_W-1:0]      raddr_a;

  always_comb begin
    front_nxt   = front_r;
    held_nxt    = held_r;
    res_err_nxt = 1'b0;
    res_sel_nxt = 1'b0;
    req_we      = 1'b0;
    req_waddr   = addr_first;
    raddr_a     = addr_first;
    swap_start  = 1'b0;
    unique case (op)
      idq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_err_nxt = 1'b1;
        end else begin
          front_nxt = addr_pfront;
          held_nxt  = held_r + 1'b1;
          req_we    = 1'b1;
          req_waddr = addr_pfront;
        end
      end
      idq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          res_err_nxt = 1'b1;
        end else begin
          held_nxt  = held_r + 1'b1;
          req_we    = 1'b1;
          req_waddr = addr_back;
        end
      end
      idq_pkg::OP_GET_FRONT: begin
        raddr_a = front_r;
        if (empty) begin
          res_err_nxt = 1'b1;
        end else begin
          res_sel_nxt = 1'b1;
          if (remove_front) begin
            front_nxt = phys(front_r, (PTR_W + 1)'(1));
            held_nxt  = held_r - 1'b1;
          end
        end
      end
      idq_pkg::OP_READ_IDX: begin
        if (!first_ok) begin
          res_err_nxt = 1'b1;
        end else begin
          res_sel_nxt = 1'b1;
        end
      end
      idq_pkg::OP_WRITE_IDX: begin
        if (!first_ok) begin
          res_err_nxt = 1'b1;
        end else begin
          req_we = 1'b1;
        end
      end
      idq_pkg::OP_SWAP: begin
        if (!first_ok || !second_ok) begin
          res_err_nxt = 1'b1;
        end else begin
          // Swapping a position with itself changes nothing.
          swap_start = (first_index != second_index);
        end
      end
      default: begin
        res_err_nxt = 1'b1;
      end
    endcase
  end

  // Swap sequencer: next state.
  always_comb begin
    sw_state_nxt = sw_state_r;
    unique case (sw_state_r)
      idq_pkg::SW_IDLE: begin
        if (in_acc && swap_start) begin
          sw_state_nxt = idq_pkg::SW_FIRST;
        end
      end
      idq_pkg::SW_FIRST:  sw_state_nxt = idq_pkg::SW_SECOND;
      idq_pkg::SW_SECOND: sw_state_nxt = idq_pkg::SW_IDLE;
      default:            sw_state_nxt = idq_pkg::SW_IDLE;
    endcase
  end

  // Swap sequencer outputs and the single slot write port.
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  always_comb begin
    swap_busy = 1'b0;
    mem_we    = in_acc && req_we;
    mem_waddr = req_waddr;
    mem_wdata = value;
    unique case (sw_state_r)
      idq_pkg::SW_IDLE: begin
        swap_busy = 1'b0;
      end
      idq_pkg::SW_FIRST: begin
        swap_busy = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = sw_a_r;
        mem_wdata = rd_b_r;
      end
      idq_pkg::SW_SECOND: begin
        swap_busy = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = sw_b_r;
        mem_wdata = rd_a_r;
      end
      default: begin
        swap_busy = 1'b0;
      end
    endcase
  end

  // Slot store: one write port, two registered read ports sampled at accept.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_a_r <= slots[raddr_a];
      rd_b_r <= slots[addr_second];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      sw_state_r  <= idq_pkg::SW_IDLE;
    end else begin
      sw_state_r <= sw_state_nxt;
      if (in_acc) begin
        front_r     <= front_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and swap addresses, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_err_r <= res_err_nxt;
      res_sel_r <= res_sel_nxt;
      res_occ_r <= held_nxt;
      sw_a_r    <= addr_first;
      sw_b_r    <= addr_second;
    end
  end

  logic [idq_pkg::VALUE_W-1:0] data_out;
  assign data_out   = res_sel_r ? idq_pkg::VALUE_W'(rd_a_r) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, idq_pkg::OCC_W'(res_occ_r), data_out};
  assign out_tuser  = res_err_r;

endmodule

FILE: hw/rtl/idq_checker.sv
// Port-level checker for the indexed deque and its bind to the top level.
// Depends on idq_pkg and on the indexed_deque port list.
module idq_checker #(
  parameter int CAPACITY = idq_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [idq_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [idq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [idq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  logic in_acc;
  logic non_read_op;
  assign in_acc      = in_tvalid && in_tready;
  assign non_read_op = (in_tuser[2:0] == idq_pkg::OP_PUSH_FRONT) ||
                       (in_tuser[2:0] == idq_pkg::OP_PUSH_BACK) ||
                       (in_tuser[2:0] == idq_pkg::OP_WRITE_IDX) ||
                       (in_tuser[2:0] == idq_pkg::OP_SWAP);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An unused operation code yields an error result in the next cycle.
  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser[2:0] == 3'd6 || in_tuser[2:0] == 3'd7)
      |=> out_tvalid && out_tuser[0])
    else $error("unused operation code not refused");

  // Operations that read nothing return zero data.
  a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && non_read_op |=> out_tvalid && (out_tdata[31:0] == '0))
    else $error("non-read operation returned data");

  // Refused requests carry zero data, and occupancy never tops capacity (checked up to 127).
  a_err_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[0] || (out_tdata[31:0] == '0)) &&
                   (CAPACITY > 127 || (int'(out_tdata[38:32]) <= CAPACITY)))
    else $error("bad error data or occupancy");

endmodule

bind indexed_deque idq_checker #(.CAPACITY(CAPACITY)) u_idq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
